FILE: rtl/core/pwsd_pkg.sv
// Package for the pairwise squared distance core: payload structs,
// field widths, transaction kind codes, register indexes and defaults.
// No dependencies.
package pwsd_pkg;

  // Field widths
  localparam int KIND_W      = 2;
  localparam int ROW_W       = 6;
  localparam int COORD_IDX_W = 4;
  localparam int COORD_W     = 16;
  localparam int DIST_W      = 37;

  // Configuration port
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 7;
  localparam int ROWS_CFG_W  = 7;
  localparam int DIMS_CFG_W  = 5;

  // Default sizing handed to the top level
  localparam int DEF_MAX_ROWS_FIRST  = 64;
  localparam int DEF_MAX_ROWS_SECOND = 64;
  localparam int DEF_MAX_DIMS        = 16;

  // Register reset values
  localparam logic [ROWS_CFG_W-1:0] RST_ROWS_FIRST  = 7'd64;
  localparam logic [ROWS_CFG_W-1:0] RST_ROWS_SECOND = 7'd64;
  localparam logic [DIMS_CFG_W-1:0] RST_DIMENSIONS  = 5'd16;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_FIRST  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS_SECOND = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIMENSIONS  = 2'd2;

  // Input transaction kinds
  localparam logic [KIND_W-1:0] KIND_LOAD_FIRST  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD_SECOND = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE     = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [ROW_W-1:0]          row_index;
    logic [COORD_IDX_W-1:0]    coord_index;
    logic signed [COORD_W-1:0] coord_value;
  } in_item_t;

  typedef struct packed {
    logic [ROW_W-1:0]  first_row;
    logic [ROW_W-1:0]  second_row;
    logic [DIST_W-1:0] distance_sq;
    logic              last;
    logic              error;
  } out_item_t;

  // Control from the sequencer to the multiply-accumulate unit
  typedef struct packed {
    logic clear;  // zero the accumulator
    logic valid;  // operand pair present this cycle
  } mac_ctrl_t;

endpackage

FILE: rtl/core/pairwise_squared_distance_core.sv
// Pairwise squared distance core: configuration registers, the two
// coordinate RAMs, the row/coordinate sequencer and the output register.
// Depends on pwsd_pkg, pwsd_ram and pwsd_mac.
//
// Usage: the input channel (in_valid_i/in_ready_o/in_item_i) takes load and
// compute transactions. A load writes one Q8.8 coordinate of the first or
// second point set; out-of-range loads are dropped.
// A compute names a first-set row and produces one result per second-set
// row on the output channel (out_valid_o/out_ready_i/out_item_o), in row
// order, with last set on the final one. A compute on a row outside the
// configured first set yields a single result with error and last set.
// Registers (row counts, dimensions) are written through cfg_we_i; the user
// must write them only while idle, as the block does not enforce it. The
// input is not ready while a compute runs. Each distance passes through the
// single difference-square-accumulate unit (one RAM read pair per coordinate,
// a drain of the unit, an emit step); output stalls lengthen a compute.
// A stalled receiver holds the finished result in the output register and
// the sequencer waits before starting the next row. Reset restores register
// defaults and idles the block; the coordinate RAMs are not cleared.
module pairwise_squared_distance_core #(
  parameter int MAX_ROWS_FIRST  = pwsd_pkg::DEF_MAX_ROWS_FIRST,
  parameter int MAX_ROWS_SECOND = pwsd_pkg::DEF_MAX_ROWS_SECOND,
  parameter int MAX_DIMS        = pwsd_pkg::DEF_MAX_DIMS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pwsd_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pwsd_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [pwsd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pwsd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pwsd_pkg::*;

  localparam int Depth1 = MAX_ROWS_FIRST * MAX_DIMS;
  localparam int Depth2 = MAX_ROWS_SECOND * MAX_DIMS;
  localparam int AW1    = (Depth1 > 1) ? $clog2(Depth1) : 1;
  localparam int AW2    = (Depth2 > 1) ? $clog2(Depth2) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_DRAIN = 3'd2;
  localparam logic [2:0] ST_EMIT  = 3'd3;
  localparam logic [2:0] ST_ERR   = 3'd4;

  logic [ROWS_CFG_W-1:0] rows_first_q, rows_second_q;
  logic [DIMS_CFG_W-1:0] dims_q;
  logic [ROWS_CFG_W-1:0] n1, n2;
  logic [DIMS_CFG_W-1:0] nd;

  logic [2:0]            state_q, state_d;
  logic [ROW_W-1:0]      row_q, row_d;
  logic [ROW_W-1:0]      r2_q, r2_d;
  logic [DIMS_CFG_W-1:0] c_q, c_d;
  logic [AW1-1:0]        a_base_q, a_base_d;
  logic [AW2-1:0]        b_base_q, b_base_d;
  logic                  rd_vld_q;

  logic                  we1, we2, rd_en;
  logic [AW1-1:0]        waddr1, raddr1;
  logic [AW2-1:0]        waddr2, raddr2;
  logic [COORD_W-1:0]    rdata1, rdata2;
  logic                  load_ok1, load_ok2, row_ok;
  logic                  last_row;

  mac_ctrl_t             mac_ctrl;
  logic [DIST_W-1:0]     mac_acc;
  logic                  mac_busy;

  logic                  out_valid_q;
  out_item_t             out_item_q, out_item_d;
  logic                  out_load;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_first_q  <= RST_ROWS_FIRST;
      rows_second_q <= RST_ROWS_SECOND;
      dims_q        <= RST_DIMENSIONS;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ROWS_FIRST:  rows_first_q  <= cfg_data_i;
        REG_ROWS_SECOND: rows_second_q <= cfg_data_i;
        REG_DIMENSIONS:  dims_q        <= cfg_data_i[DIMS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective counts: zero acts as one, values above the maximum saturate
  always_comb begin
    n1 = rows_first_q;
    if (rows_first_q == '0) begin
      n1 = ROWS_CFG_W'(1);
    end else if (32'(rows_first_q) > 32'(MAX_ROWS_FIRST)) begin
      n1 = ROWS_CFG_W'(MAX_ROWS_FIRST);
    end
    n2 = rows_second_q;
    if (rows_second_q == '0) begin
      n2 = ROWS_CFG_W'(1);
    end else if (32'(rows_second_q) > 32'(MAX_ROWS_SECOND)) begin
      n2 = ROWS_CFG_W'(MAX_ROWS_SECOND);
    end
    nd = dims_q;
    if (dims_q == '0) begin
      nd = DIMS_CFG_W'(1);
    end else if (32'(dims_q) > 32'(MAX_DIMS)) begin
      nd = DIMS_CFG_W'(MAX_DIMS);
    end
  end

  // Range checks and write addresses for loads
  assign row_ok   = {1'b0, in_item_i.row_index} < n1;
  assign load_ok1 = row_ok && ({1'b0, in_item_i.coord_index} < nd);
  assign load_ok2 = ({1'b0, in_item_i.row_index} < n2) &&
                    ({1'b0, in_item_i.coord_index} < nd);
  assign waddr1   = AW1'(32'(in_item_i.row_index) * 32'(MAX_DIMS) +
                         32'(in_item_i.coord_index));
  assign waddr2   = AW2'(32'(in_item_i.row_index) * 32'(MAX_DIMS) +
                         32'(in_item_i.coord_index));

  // Read addresses walk one coordinate per cycle
  assign raddr1   = a_base_q + AW1'(c_q);
  assign raddr2   = b_base_q + AW2'(c_q);
  assign last_row = (ROWS_CFG_W'(r2_q) + ROWS_CFG_W'(1)) == n2;

  // Sequencer
  always_comb begin
    state_d    = state_q;
    row_d      = row_q;
    r2_d       = r2_q;
    c_d        = c_q;
    a_base_d   = a_base_q;
    b_base_d   = b_base_q;
    we1        = 1'b0;
    we2        = 1'b0;
    rd_en      = 1'b0;
    mac_ctrl   = '0;
    out_load   = 1'b0;
    out_item_d = out_item_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_item_i.kind)
            KIND_LOAD_FIRST:  we1 = load_ok1;
            KIND_LOAD_SECOND: we2 = load_ok2;
            KIND_COMPUTE: begin
              row_d = in_item_i.row_index;
              if (row_ok) begin
                a_base_d       = AW1'(32'(in_item_i.row_index) * 32'(MAX_DIMS));
                b_base_d       = '0;
                r2_d           = '0;
                c_d            = '0;
                mac_ctrl.clear = 1'b1;
                state_d        = ST_RUN;
              end else begin
                state_d = ST_ERR;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        rd_en = 1'b1;
        if (c_q == nd - DIMS_CFG_W'(1)) begin
          c_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          c_d = c_q + DIMS_CFG_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!rd_vld_q && !mac_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load               = 1'b1;
          out_item_d.first_row   = row_q;
          out_item_d.second_row  = r2_q;
          out_item_d.distance_sq = mac_acc;
          out_item_d.last        = last_row;
          out_item_d.error       = 1'b0;
          if (last_row) begin
            state_d = ST_IDLE;
          end else begin
            r2_d           = r2_q + ROW_W'(1);
            b_base_d       = b_base_q + AW2'(MAX_DIMS);
            mac_ctrl.clear = 1'b1;
            state_d        = ST_RUN;
          end
        end
      end
      ST_ERR: begin
        if (!out_valid_q || out_ready_i) begin
          out_load               = 1'b1;
          out_item_d.first_row   = row_q;
          out_item_d.second_row  = '0;
          out_item_d.distance_sq = '0;
          out_item_d.last        = 1'b1;
          out_item_d.error       = 1'b1;
          state_d                = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    mac_ctrl.valid = rd_vld_q;
  end

  assign in_ready_o = (state_q == ST_IDLE);

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      r2_q        <= '0;
      c_q         <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      r2_q     <= r2_d;
      c_q      <= c_d;
      rd_vld_q <= rd_en;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    row_q    <= row_d;
    a_base_q <= a_base_d;
    b_base_q <= b_base_d;
    if (out_load) begin
      out_item_q <= out_item_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // Coordinate stores
  pwsd_ram #(
    .WIDTH (COORD_W),
    .DEPTH (Depth1)
  ) u_first_ram (
    .clk_i   (clk_i),
    .we_i    (we1),
    .waddr_i (waddr1),
    .wdata_i (in_item_i.coord_value),
    .re_i    (rd_en),
    .raddr_i (raddr1),
    .rdata_o (rdata1)
  );

  pwsd_ram #(
    .WIDTH (COORD_W),
    .DEPTH (Depth2)
  ) u_second_ram (
    .clk_i   (clk_i),
    .we_i    (we2),
    .waddr_i (waddr2),
    .wdata_i (in_item_i.coord_value),
    .re_i    (rd_en),
    .raddr_i (raddr2),
    .rdata_o (rdata2)
  );

  // Shared difference-square-accumulate unit
  pwsd_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .a_i    (rdata1),
    .b_i    (rdata2),
    .acc_o  (mac_acc),
    .busy_o (mac_busy)
  );

  // Accumulator is only cleared with nothing in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_ctrl.clear |-> (!rd_vld_q && !mac_busy))
    else $error("accumulator cleared with operands in flight");

  // A result is only emitted once the pipeline has drained
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (!rd_vld_q && !mac_busy))
    else $error("distance emitted before pipeline drained");

  // An error result is a single, final, zero-distance transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.error) |->
      (out_item_o.last && (out_item_o.distance_sq == '0)))
    else $error("malformed error result");

  // An accepted compute takes the input out of ready right after it is accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && (in_item_i.kind == KIND_COMPUTE)) |=> !in_ready_o)
    else $error("input ready right after a compute transaction");

endmodule

FILE: rtl/core/pwsd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module pwsd_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/pwsd_mac.sv
// Shared difference-square-accumulate unit: |a-b|, square, running sum.
// Depends on pwsd_pkg.
module pwsd_mac (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pwsd_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [pwsd_pkg::COORD_W-1:0]  a_i,
  input  logic signed [pwsd_pkg::COORD_W-1:0]  b_i,
  output logic [pwsd_pkg::DIST_W-1:0]          acc_o,
  output logic                                 busy_o
);
  import pwsd_pkg::*;

  logic signed [COORD_W:0]  diff;
  logic [COORD_W:0]         diff_neg;
  logic [COORD_W-1:0]       absd_d, absd_q;
  logic [2*COORD_W-1:0]     sq_q;
  logic                     absd_vld_q, sq_vld_q;
  logic [DIST_W-1:0]        acc_q;

  // Stage 1: magnitude of the difference, fits COORD_W bits unsigned
  always_comb begin
    diff     = {a_i[COORD_W-1], a_i} - {b_i[COORD_W-1], b_i};
    diff_neg = ~diff + 1'b1;
    absd_d   = diff[COORD_W] ? diff_neg[COORD_W-1:0] : diff[COORD_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      absd_vld_q <= 1'b0;
      sq_vld_q   <= 1'b0;
    end else begin
      absd_vld_q <= ctrl_i.valid;
      sq_vld_q   <= absd_vld_q;
    end
  end

  // Stage 2: square; stage 3: accumulate (wraps at DIST_W bits)
  always_ff @(posedge clk_i) begin
    absd_q <= absd_d;
    sq_q   <= absd_q * absd_q;
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (sq_vld_q) begin
      acc_q <= acc_q + DIST_W'(sq_q);
    end
  end

  assign acc_o  = acc_q;
  assign busy_o = absd_vld_q | sq_vld_q;

endmodule

FILE: sim/tb_pairwise_squared_distance_core.sv
// Self-checking testbench for pairwise_squared_distance_core: loads point sets,
// runs row computes and checks every distance against an in-bench predictor.
// Depends on pwsd_pkg and the core RTL.
module tb_pairwise_squared_distance_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pwsd_pkg::*;

  localparam int STRIDE       = DEF_MAX_DIMS;
  localparam int STORE_DEPTH  = DEF_MAX_ROWS_FIRST * DEF_MAX_DIMS;
  localparam int SETTLE_CYCLES = 10;
  localparam int DRAIN_CYCLES  = 100;
  localparam int PHASE_ITEMS   = 34;
  localparam longint TIMEOUT_NS = 50_000_000;

  // Kind code the block must ignore
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [COORD_W-1:0] COORD_MIN = 16'h8000;
  localparam logic [COORD_W-1:0] COORD_MAX = 16'h7FFF;

  // Mirror of both point stores and the registers; predicts distance results
  class distance_tracker;
    logic [COORD_W-1:0] first_pts [STORE_DEPTH];
    logic [COORD_W-1:0] second_pts [STORE_DEPTH];
    bit first_known [STORE_DEPTH];
    bit second_known [STORE_DEPTH];
    logic [ROWS_CFG_W-1:0] rows_first_reg;
    logic [ROWS_CFG_W-1:0] rows_second_reg;
    logic [DIMS_CFG_W-1:0] dims_reg;
    out_item_t pending_distances[$];
    int mismatches, loads, computes, bad_rows, ignored, results;

    function new();
      rows_first_reg  = RST_ROWS_FIRST;
      rows_second_reg = RST_ROWS_SECOND;
      dims_reg        = RST_DIMENSIONS;
    endfunction

    // Zero acts as one, anything above the maximum acts as the maximum
    function int clamp(int v, int maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
    endfunction

    function int n_first();
      return clamp(int'(rows_first_reg), DEF_MAX_ROWS_FIRST);
    endfunction

    function int n_second();
      return clamp(int'(rows_second_reg), DEF_MAX_ROWS_SECOND);
    endfunction

    function int n_dims();
      return clamp(int'(dims_reg), DEF_MAX_DIMS);
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_ROWS_FIRST:  rows_first_reg  = data[ROWS_CFG_W-1:0];
        REG_ROWS_SECOND: rows_second_reg = data[ROWS_CFG_W-1:0];
        REG_DIMENSIONS:  dims_reg        = data[DIMS_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    // Exact sum of squared coordinate differences
    function logic [DIST_W-1:0] sq_distance(int r1, int r2);
      longint acc;
      int a, b, d;
      acc = 0;
      for (int c = 0; c < n_dims(); c++) begin
        a = int'($signed(first_pts[r1 * STRIDE + c]));
        b = int'($signed(second_pts[r2 * STRIDE + c]));
        d = a - b;
        acc += longint'(d) * longint'(d);
      end
      return acc[DIST_W-1:0];
    endfunction

    // Called for every accepted input transaction
    function void note_item(in_item_t item);
      int row, coord, limit;
      out_item_t e;
      row   = int'(item.row_index);
      coord = int'(item.coord_index);
      case (item.kind)
        KIND_LOAD_FIRST, KIND_LOAD_SECOND: begin
          limit = (item.kind == KIND_LOAD_FIRST) ? n_first() : n_second();
          if (row < limit && coord < n_dims()) begin
            loads++;
            if (item.kind == KIND_LOAD_FIRST) begin
              first_pts[row * STRIDE + coord]   = item.coord_value;
              first_known[row * STRIDE + coord] = 1'b1;
            end else begin
              second_pts[row * STRIDE + coord]   = item.coord_value;
              second_known[row * STRIDE + coord] = 1'b1;
            end
          end else begin
            ignored++;
          end
        end
        KIND_COMPUTE: begin
          computes++;
          if (row >= n_first()) begin
            // Row outside the first set: one flagged result
            bad_rows++;
            e.first_row   = item.row_index;
            e.second_row  = '0;
            e.distance_sq = '0;
            e.last        = 1'b1;
            e.error       = 1'b1;
            pending_distances.push_back(e);
          end else begin
            for (int r2 = 0; r2 < n_second(); r2++) begin
              e.first_row   = item.row_index;
              e.second_row  = r2[ROW_W-1:0];
              e.distance_sq = sq_distance(row, r2);
              e.last        = (r2 == n_second() - 1);
              e.error       = 1'b0;
              pending_distances.push_back(e);
            end
          end
        end
        default: ignored++;
      endcase
    endfunction

    function void compare_field(string field, logic [DIST_W-1:0] want,
                                logic [DIST_W-1:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    // Called for every accepted result transaction
    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_distances.size() == 0) begin
        $error("unexpected result: first_row %0d second_row %0d distance_sq %0d",
               got.first_row, got.second_row, got.distance_sq);
        mismatches++;
        return;
      end
      e = pending_distances.pop_front();
      results++;
      compare_field("first_row", DIST_W'(e.first_row), DIST_W'(got.first_row));
      compare_field("second_row", DIST_W'(e.second_row), DIST_W'(got.second_row));
      compare_field("distance_sq", e.distance_sq, got.distance_sq);
      compare_field("last", DIST_W'(e.last), DIST_W'(got.last));
      compare_field("error", DIST_W'(e.error), DIST_W'(got.error));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_item_t in_item_i;
  logic out_valid_o;
  logic out_ready_i;
  out_item_t out_item_o;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;
  int settings_seen   = 0;
  int items_sent      = 0;
  distance_tracker tracker = new();

  pairwise_squared_distance_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Receiver: random stalls, changed on the falling edge
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) tracker.check_result(out_item_o);
  end

  // Biased coordinate: extremes, zero and small values show up often
  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 7))
      0: return COORD_MIN;
      1: return COORD_MAX;
      2: return '0;
      3: return 16'($urandom_range(0, 1023) - 512);
      default: return 16'($urandom);
    endcase
  endfunction

  // Drive one input transaction; starts and ends on a falling edge
  task automatic send_item(input in_item_t item);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.note_item(item);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_fields(input logic [KIND_W-1:0] kind, input int row, input int coord,
                             input logic [COORD_W-1:0] value);
    in_item_t item;
    item.kind        = kind;
    item.row_index   = row[ROW_W-1:0];
    item.coord_index = coord[COORD_IDX_W-1:0];
    item.coord_value = value;
    send_item(item);
  endtask

  task automatic write_reg_port(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    tracker.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  // Drain the block, then rewrite all registers and pick the idling pattern
  task automatic configure(input logic [CFG_DATA_W-1:0] rf, input logic [CFG_DATA_W-1:0] rs,
                           input logic [CFG_DATA_W-1:0] dims, input int sidle,
                           input int rstall);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (tracker.pending_distances.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    write_reg_port(REG_ROWS_FIRST, rf);
    write_reg_port(REG_ROWS_SECOND, rs);
    write_reg_port(REG_DIMENSIONS, dims);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    sender_idle_pct = sidle;
    recv_stall_pct  = rstall;
    settings_seen++;
  endtask

  // Compute one in-range row, loading any coordinate it needs first
  task automatic compute_row(input int r);
    int n2, nd;
    n2 = tracker.n_second();
    nd = tracker.n_dims();
    for (int c = 0; c < nd; c++) begin
      if (!tracker.first_known[r * STRIDE + c]) send_fields(KIND_LOAD_FIRST, r, c, rand_coord());
    end
    for (int r2 = 0; r2 < n2; r2++) begin
      for (int c = 0; c < nd; c++) begin
        if (!tracker.second_known[r2 * STRIDE + c])
          send_fields(KIND_LOAD_SECOND, r2, c, rand_coord());
      end
    end
    send_fields(KIND_COMPUTE, r, $urandom_range(0, 15), 16'($urandom));
  endtask

  // Random mix: mostly loads and computes on valid rows, some noise and misses
  task automatic random_phase(input int budget);
    int start, roll, row, coord, n1, n2, nd;
    bit to_second, extreme;
    logic [KIND_W-1:0] kind;
    start = items_sent;
    while (items_sent - start < budget) begin
      n1   = tracker.n_first();
      n2   = tracker.n_second();
      nd   = tracker.n_dims();
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        send_fields(KIND_UNUSED, $urandom_range(0, 63), $urandom_range(0, 15), 16'($urandom));
      end else if (roll < 18) begin
        // Any kind, any index: loads may be dropped, computes may miss
        kind  = 2'($urandom_range(0, 2));
        row   = $urandom_range(0, 63);
        coord = $urandom_range(0, 15);
        if (kind == KIND_COMPUTE && row < n1) compute_row(row);
        else send_fields(kind, row, coord, 16'($urandom));
      end else if (roll < 42) begin
        if (n1 < DEF_MAX_ROWS_FIRST && $urandom_range(0, 7) == 0)
          send_fields(KIND_COMPUTE, $urandom_range(n1, 63), $urandom_range(0, 15),
                      16'($urandom));
        else
          compute_row($urandom_range(0, n1 - 1));
      end else if (roll < 56) begin
        // Whole point in one burst, sometimes at the coordinate extremes
        to_second = 1'($urandom_range(0, 1));
        extreme   = ($urandom_range(0, 2) == 0);
        row = $urandom_range(0, (to_second ? n2 : n1) - 1);
        for (int c = 0; c < nd; c++) begin
          send_fields(to_second ? KIND_LOAD_SECOND : KIND_LOAD_FIRST, row, c,
                      extreme ? (to_second ? COORD_MAX : COORD_MIN) : rand_coord());
        end
      end else begin
        to_second = 1'($urandom_range(0, 1));
        send_fields(to_second ? KIND_LOAD_SECOND : KIND_LOAD_FIRST,
                    $urandom_range(0, (to_second ? n2 : n1) - 1), $urandom_range(0, nd - 1),
                    rand_coord());
      end
    end
  endtask

  // Run limit
  initial begin
    #(TIMEOUT_NS);
    $display("Timed out with %0d results outstanding", tracker.pending_distances.size());
    $display("FAILURE");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_ready_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: two rows per set, two dimensions
    configure(7'd2, 7'd2, 7'd2, 0, 0);
    send_fields(KIND_UNUSED, 63, 15, 16'hFFFF);
    send_fields(KIND_LOAD_FIRST, 0, 0, COORD_MIN);
    send_fields(KIND_LOAD_FIRST, 0, 1, COORD_MAX);
    send_fields(KIND_LOAD_FIRST, 1, 0, 16'h0100);
    send_fields(KIND_LOAD_FIRST, 1, 1, 16'hFFFF);
    send_fields(KIND_LOAD_SECOND, 0, 0, COORD_MAX);
    send_fields(KIND_LOAD_SECOND, 0, 1, COORD_MIN);
    send_fields(KIND_LOAD_SECOND, 1, 0, 16'h0000);
    send_fields(KIND_LOAD_SECOND, 1, 1, 16'h0000);
    // Dropped loads: row past the set, coordinate past the dimensions
    send_fields(KIND_LOAD_FIRST, 2, 0, 16'h5555);
    send_fields(KIND_LOAD_SECOND, 0, 2, 16'h007B);
    send_fields(KIND_LOAD_SECOND, 63, 15, COORD_MIN);
    send_fields(KIND_COMPUTE, 0, 0, 16'h0000);
    send_fields(KIND_COMPUTE, 1, 15, 16'hFFFF);
    // Compute rows outside the first set
    send_fields(KIND_COMPUTE, 2, 0, 16'h0000);
    send_fields(KIND_COMPUTE, 63, 9, 16'hA5A5);
    send_fields(KIND_UNUSED, 0, 0, 16'h0000);

    // Random phases over several register settings and idling patterns
    configure(7'd0, 7'd0, 7'd0, 59, 0);
    random_phase(PHASE_ITEMS);
    configure(7'd2, 7'd2, 7'd16, 0, 0);
    random_phase(PHASE_ITEMS);
    configure(7'd127, 7'd100, 7'd1, 0, 59);
    random_phase(PHASE_ITEMS);
    configure(7'd5, 7'd3, 7'd127, 26, 26);
    random_phase(PHASE_ITEMS);
    configure(7'd64, 7'd1, 7'd4, 59, 0);
    random_phase(PHASE_ITEMS);
    configure(7'd10, 7'd6, 7'd7, 0, 59);
    random_phase(PHASE_ITEMS);
    configure(7'd1, 7'd17, 7'd2, 26, 26);
    random_phase(PHASE_ITEMS);
    configure(7'd40, 7'd8, 7'd3, 0, 0);
    random_phase(PHASE_ITEMS);

    // Wait for the last results, then a short drain
    in_valid_i <= 1'b0;
    while (tracker.pending_distances.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Covered %0d input transactions: %0d coordinate loads, %0d row computes (%0d %s",
             items_sent, tracker.loads, tracker.computes, tracker.bad_rows,
             "on rows outside the set)");
    $display("%0d distances checked, %0d ignored transactions, %0d register settings",
             tracker.results, tracker.ignored, settings_seen);
    if (tracker.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
